// File: rtl/note_delta_stream_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the note delta stream encoder
// Shared checks are written through these macros, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NOTE_DELTA_STREAM_ENCODER_UNIT_DEFINES_SVH
`define NOTE_DELTA_STREAM_ENCODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NDS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nds_pkg.sv
// ----------------------------------------------------------------------------
// nds_pkg
// Types and constants shared by the note delta stream encoder modules.
// ----------------------------------------------------------------------------
package nds_pkg;

  // Longest delta run in bytes and the largest delta that fits in it.
  localparam int MaxDeltaBytes = 61;
  localparam int DeltaCap      = MaxDeltaBytes * 255 - 1;
  localparam int DeltaW        = $clog2(DeltaCap + 1);

  localparam logic [7:0] FullByte    = 8'hFF;
  localparam logic [7:0] EndByte     = 8'hFF;
  localparam logic [7:0] MarkerPitch = 8'd128;
  localparam logic [7:0] LastFlag    = 8'h80;

  localparam int PaddrW = 4;

  typedef enum logic [1:0] {
    REG_TRANSPOSE,
    REG_LOWEST,
    REG_HIGHEST,
    REG_OFFSET
  } reg_idx_e;

  // Which byte source the datapath drives into the output register.
  typedef enum logic [1:0] {
    PH_CLOSE,
    PH_DELTA,
    PH_HELD,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    logic [7:0] transpose_amount;
    logic [6:0] lowest_valid;
    logic [6:0] highest_valid;
    logic [6:0] pitch_offset;
  } cfg_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    phase_e phase;
    logic   last;
  } cmd_t;

  typedef struct packed {
    logic send_close;
    logic send_delta;
    logic send_held;
    logic send_tail;
    logic delta_big;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/nds_dp.sv
// ----------------------------------------------------------------------------
// nds_dp
// Datapath: pitch filter, song state, byte plan of the current item, delta
// counter and the output register.
// ----------------------------------------------------------------------------
module nds_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nds_pkg::cmd_t  cmd_i,
  output nds_pkg::sts_t  sts_o,
  input  nds_pkg::cfg_t  cfg_i,
  input  logic           operation_i,
  input  logic [15:0]    tick_i,
  input  logic [7:0]     pitch_i,
  input  logic           last_in_tick_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     data_byte_o,
  output logic           last_o,
  output logic           delta_clamped_o
);
  import nds_pkg::*;

  // Song state.
  logic [15:0] prev_tick_q;
  logic        group_open_q;
  logic        held_valid_q;
  logic [7:0]  held_byte_q;

  // Plan of the item being sent.
  logic              send_close_q, send_delta_q, send_held_q, send_tail_q;
  logic [7:0]        close_byte_q, held_out_q, tail_byte_q;
  logic [DeltaW-1:0] cnt_q;
  logic              clamped_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       clamp_out_q;

  logic [9:0]        shifted;
  logic              in_range, kept;
  logic [7:0]        code;
  logic              changed, open_after, backwards, over;
  logic [15:0]       diff;
  logic [DeltaW-1:0] delta;
  logic              send_close, send_delta, send_held, send_tail;
  logic [7:0]        tail_byte, emit_byte;

  always_comb begin
    shifted  = {2'b00, pitch_i} + {{2{cfg_i.transpose_amount[7]}}, cfg_i.transpose_amount};
    in_range = !shifted[9] && (shifted[8:0] >= {2'b00, cfg_i.lowest_valid})
                           && (shifted[8:0] <= {2'b00, cfg_i.highest_valid});
    kept     = (pitch_i == MarkerPitch) || in_range;
    code     = (pitch_i == MarkerPitch) ? MarkerPitch
                                        : shifted[7:0] - {1'b0, cfg_i.pitch_offset};

    changed    = tick_i != prev_tick_q;
    open_after = !operation_i && group_open_q && !changed;
    backwards  = tick_i < prev_tick_q;
    diff       = tick_i - prev_tick_q;
    over       = diff > 16'(DeltaCap);
    if (backwards) begin
      delta = '0;
    end else if (over) begin
      delta = DeltaW'(DeltaCap);
    end else begin
      delta = diff[DeltaW-1:0];
    end

    send_close = held_valid_q && (operation_i || changed);
    send_delta = operation_i || (kept && !open_after);
    send_held  = !operation_i && kept && open_after && held_valid_q;
    send_tail  = operation_i || (last_in_tick_i && (kept || (open_after && held_valid_q)));
    tail_byte  = operation_i ? EndByte : ((kept ? code : held_byte_q) | LastFlag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tick_q  <= '0;
      group_open_q <= 1'b0;
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
    end else if (cmd_i.load) begin
      if (operation_i) begin
        prev_tick_q  <= '0;
        group_open_q <= 1'b0;
        held_valid_q <= 1'b0;
        held_byte_q  <= '0;
      end else begin
        if (send_delta) begin
          prev_tick_q <= tick_i;
        end
        group_open_q <= (open_after || kept) && !last_in_tick_i;
        held_valid_q <= (kept || (open_after && held_valid_q)) && !last_in_tick_i;
        if (kept) begin
          held_byte_q <= code;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_close_q <= 1'b0;
      send_delta_q <= 1'b0;
      send_held_q  <= 1'b0;
      send_tail_q  <= 1'b0;
    end else if (cmd_i.load) begin
      send_close_q <= send_close;
      send_delta_q <= send_delta;
      send_held_q  <= send_held;
      send_tail_q  <= send_tail;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      close_byte_q <= held_byte_q | LastFlag;
      held_out_q   <= held_byte_q;
      tail_byte_q  <= tail_byte;
      cnt_q        <= delta;
      clamped_q    <= send_delta && (backwards || over);
    end else if (cmd_i.emit && cmd_i.phase == PH_DELTA && sts_o.delta_big) begin
      cnt_q <= cnt_q - DeltaW'(255);
    end
  end

  always_comb begin
    unique case (cmd_i.phase)
      PH_CLOSE: emit_byte = close_byte_q;
      PH_DELTA: emit_byte = sts_o.delta_big ? FullByte : cnt_q[7:0];
      PH_HELD:  emit_byte = held_out_q;
      PH_TAIL:  emit_byte = tail_byte_q;
      default:  emit_byte = tail_byte_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      data_q      <= emit_byte;
      last_q      <= cmd_i.last;
      clamp_out_q <= clamped_q;
    end
  end

  always_comb begin
    sts_o.send_close = send_close_q;
    sts_o.send_delta = send_delta_q;
    sts_o.send_held  = send_held_q;
    sts_o.send_tail  = send_tail_q;
    sts_o.delta_big  = cnt_q >= DeltaW'(255);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = data_q;
  assign last_o          = last_q;
  assign delta_clamped_o = clamp_out_q;

endmodule

// File: rtl/nds_ctrl.sv
// ----------------------------------------------------------------------------
// nds_ctrl
// Controller: accepts an item, then walks the byte plan in stream order,
// one byte per cycle whenever the output register has room.
// ----------------------------------------------------------------------------
`include "note_delta_stream_encoder_unit_defines.svh"

module nds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nds_pkg::sts_t sts_i,
  output nds_pkg::cmd_t cmd_o
);
  import nds_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_CLOSE,
    ST_DELTA,
    ST_HELD,
    ST_TAIL
  } state_e;

  state_e state_q, state_d;
  state_e after_close, after_delta, after_held;

  always_comb begin
    after_held  = sts_i.send_tail ? ST_TAIL : ST_IDLE;
    after_delta = sts_i.send_held ? ST_HELD : after_held;
    after_close = sts_i.send_delta ? ST_DELTA : after_delta;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.phase = PH_CLOSE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        state_d = sts_i.send_close ? ST_CLOSE : after_close;
      end
      ST_CLOSE: begin
        cmd_o.phase = PH_CLOSE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = after_close == ST_IDLE;
          state_d    = after_close;
        end
      end
      ST_DELTA: begin
        cmd_o.phase = PH_DELTA;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = !sts_i.delta_big && after_delta == ST_IDLE;
          if (!sts_i.delta_big) begin
            state_d = after_delta;
          end
        end
      end
      ST_HELD: begin
        cmd_o.phase = PH_HELD;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = after_held == ST_IDLE;
          state_d    = after_held;
        end
      end
      ST_TAIL: begin
        cmd_o.phase = PH_TAIL;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

  `NDS_ASSERT_SAME(a_emit_needs_room, cmd_o.emit, sts_i.out_free, "byte emitted into a full output register")
  `NDS_ASSERT_NEXT(a_load_dispatches, cmd_o.load, state_q == ST_DISP, "accepted item was not dispatched")
  `NDS_ASSERT_NEXT(a_delta_run_stays, state_q == ST_DELTA && cmd_o.emit && sts_i.delta_big, state_q == ST_DELTA, "delta run left before its final byte")
  `NDS_ASSERT_SAME(a_tail_is_last, cmd_o.emit && cmd_o.phase == PH_TAIL, cmd_o.last, "tail byte not marked last")

endmodule

// File: rtl/note_delta_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// note_delta_stream_encoder_unit
// Encodes note events into a byte stream of tick deltas and note codes.
// ----------------------------------------------------------------------------
// After acceptance an item passes the dispatch state; each byte state then registers one byte.
// An item sends 0 to 63 bytes, one byte a cycle while the output register has room.
// The delta run of up to 61 bytes is produced by a counter, one byte per cycle while not stalled.
// Output stalls add cycles; the next item is taken in the cycle after the last byte is registered.
// Reset is asynchronous and active low; it returns config, control, output valid and song state to defaults.
// ----------------------------------------------------------------------------
module note_delta_stream_encoder_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [nds_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Input items.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [15:0]               tick_i,
  input  logic [7:0]                pitch_i,
  input  logic                      last_in_tick_i,
  // Result items.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                data_byte_o,
  output logic                      last_o,
  output logic                      delta_clamped_o
);
  import nds_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  cmd_t     cmd;
  sts_t     sts;

  // The register file never waits; every access completes in its access cycle.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PaddrW-1:2]);

  // The user must see that registers are written only while no item is in flight,
  // so the datapath reads them directly; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.transpose_amount <= 8'd0;
      cfg_q.lowest_valid     <= 7'd0;
      cfg_q.highest_valid    <= 7'd127;
      cfg_q.pitch_offset     <= 7'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_TRANSPOSE: cfg_q.transpose_amount <= pwdata[7:0];
        REG_LOWEST:    cfg_q.lowest_valid     <= pwdata[6:0];
        REG_HIGHEST:   cfg_q.highest_valid    <= pwdata[6:0];
        REG_OFFSET:    cfg_q.pitch_offset     <= pwdata[6:0];
        default:       cfg_q.pitch_offset     <= cfg_q.pitch_offset;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRANSPOSE: prdata = {24'd0, cfg_q.transpose_amount};
      REG_LOWEST:    prdata = {25'd0, cfg_q.lowest_valid};
      REG_HIGHEST:   prdata = {25'd0, cfg_q.highest_valid};
      REG_OFFSET:    prdata = {25'd0, cfg_q.pitch_offset};
      default:       prdata = 32'd0;
    endcase
  end

  // The controller sequences the bytes of one item at a time; the datapath
  // computes the whole byte plan and the new song state when the item loads.
  nds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nds_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_i           (cfg_q),
    .operation_i     (operation_i),
    .tick_i          (tick_i),
    .pitch_i         (pitch_i),
    .last_in_tick_i  (last_in_tick_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_byte_o     (data_byte_o),
    .last_o          (last_o),
    .delta_clamped_o (delta_clamped_o)
  );

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Note delta stream encoder testbench
// Drives note and end-of-song items into the encoder and checks every encoded
// byte against a predictor of its own, across several register settings
// and both directions of back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nds_pkg::*;

  // Operation codes of an input item.
  localparam logic OP_NOTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Cycles without any handshake before the run is declared hung. The long
  // receiver hold-off below is well inside this.
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 400;

  typedef struct {
    logic        op;
    logic [15:0] tick;
    logic [7:0]  pitch;
    logic        last_in;
  } note_event_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       clamped;
  } stream_byte_t;

  // DUT connections. Every input starts at a known value.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PaddrW-1:0]   paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                operation_i    = 1'b0;
  logic [15:0]         tick_i         = '0;
  logic [7:0]          pitch_i        = '0;
  logic                last_in_tick_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [7:0]          data_byte_o;
  logic                last_o;
  logic                delta_clamped_o;

  note_delta_stream_encoder_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .tick_i          (tick_i),
    .pitch_i         (pitch_i),
    .last_in_tick_i  (last_in_tick_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_byte_o     (data_byte_o),
    .last_o          (last_o),
    .delta_clamped_o (delta_clamped_o)
  );

  // Items waiting to be driven, and the encoded bytes the block still owes.
  note_event_t  pending_events[$];
  stream_byte_t expected_bytes[$];
  note_event_t  drive_event;
  stream_byte_t want;

  int issued_count   = 0;
  int accepted_count = 0;
  int byte_count     = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Idling percentages, changed only between phases by the sequence below.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold-off, requested once and counted by the stall driver.
  logic pressure_req  = 1'b0;
  logic pressure_done = 1'b0;
  int   hold_left     = 0;

  // Set at each rising edge when the block took an item; the driver reads it
  // at the following falling edge.
  logic event_taken = 1'b0;

  // Testbench copy of the registers, updated as each write lands.
  logic signed [7:0] cfg_transpose = 8'sd0;
  logic [6:0]        cfg_lowest    = 7'd0;
  logic [6:0]        cfg_highest   = 7'd127;
  logic [6:0]        cfg_offset    = 7'd0;

  // Song state of the predictor.
  logic [15:0] song_prev_tick  = '0;
  logic        song_group_open = 1'b0;
  logic        song_held_valid = 1'b0;
  logic [7:0]  song_held_byte  = '0;

  // Bytes of the item being predicted, and whether its delta was clamped.
  logic [7:0] encoded_run[$];
  logic       run_clamped;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Closing a group releases the held note with the last-of-group flag set.
  function automatic void close_group();
    if (song_held_valid) begin
      encoded_run = {encoded_run, song_held_byte | LastFlag};
    end
    song_held_valid = 1'b0;
    song_group_open = 1'b0;
  endfunction

  // The tick delta goes out as a run of full bytes and one byte below 255.
  // A tick that moves backwards sends zero, and a delta above the cap is cut
  // to the cap; both set the clamp flag on every byte of the item.
  function automatic void send_delta(logic [15:0] tick);
    int d;
    if (tick < song_prev_tick) begin
      d = 0;
      run_clamped = 1'b1;
    end else begin
      d = int'(tick) - int'(song_prev_tick);
      if (d > DeltaCap) begin
        d = DeltaCap;
        run_clamped = 1'b1;
      end
    end
    song_prev_tick = tick;
    while (d >= 255) begin
      encoded_run = {encoded_run, FullByte};
      d -= 255;
    end
    encoded_run = {encoded_run, 8'(d)};
  endfunction

  function automatic void encode_event(note_event_t ev);
    logic         kept;
    logic [7:0]   code;
    int           shifted;
    stream_byte_t sb;
    encoded_run.delete();
    run_clamped = 1'b0;
    kept = 1'b0;
    code = '0;
    if (ev.op == OP_END) begin
      // End of song: close, send the final delta and the end byte, then the
      // song state starts over while the registers stay.
      close_group();
      send_delta(ev.tick);
      encoded_run = {encoded_run, EndByte};
      song_prev_tick  = '0;
      song_group_open = 1'b0;
      song_held_valid = 1'b0;
      song_held_byte  = '0;
    end else begin
      // A new tick inside an open group closes that group first.
      if (song_group_open && ev.tick != song_prev_tick) begin
        close_group();
      end
      if (ev.pitch == MarkerPitch) begin
        // The marker is always kept and never transposed.
        kept = 1'b1;
        code = MarkerPitch;
      end else begin
        shifted = int'(ev.pitch) + int'(cfg_transpose);
        if (shifted >= int'(cfg_lowest) && shifted <= int'(cfg_highest)) begin
          kept = 1'b1;
          code = 8'(shifted - int'(cfg_offset));
        end
      end
      if (kept) begin
        if (!song_group_open) begin
          send_delta(ev.tick);
          song_group_open = 1'b1;
        end else if (song_held_valid) begin
          encoded_run = {encoded_run, song_held_byte};
        end
        song_held_byte  = code;
        song_held_valid = 1'b1;
      end
      if (ev.last_in) begin
        close_group();
      end
    end
    foreach (encoded_run[k]) begin
      sb = '{encoded_run[k], k == encoded_run.size() - 1, run_clamped};
      expected_bytes = {expected_bytes, sb};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver, stall driver, monitor and watchdog
  // --------------------------------------------------------------------------

  // The input side changes on the falling edge. Once valid is up it stays up,
  // with the payload unchanged, until the block has taken the item.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || event_taken) begin
      if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_event = pending_events.pop_front();
        in_valid_i     <= 1'b1;
        operation_i    <= drive_event.op;
        tick_i         <= drive_event.tick;
        pitch_i        <= drive_event.pitch;
        last_in_tick_i <= drive_event.last_in;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, and once holds off for a long stretch so
  // that the block fills up and pushes back on its input.
  always @(negedge clk_i) begin
    if (pressure_req && !pressure_done) begin
      hold_left = HoldCycles;
      pressure_done = 1'b1;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Handshakes are sampled on the rising edge. A newly taken item is
  // predicted before the byte leaving at the same edge is checked, which is
  // safe since that byte always belongs to an older item.
  always @(posedge clk_i) begin
    event_taken = rst_ni && in_valid_i && !in_stall_o;
    if (event_taken) begin
      accepted_count++;
      encode_event('{operation_i, tick_i, pitch_i, last_in_tick_i});
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %0d: unexpected data %02h last %0b clamped %0b",
                                  byte_count, data_byte_o, last_o, delta_clamped_o));
      end else begin
        want = expected_bytes.pop_front();
        if (data_byte_o !== want.data || last_o !== want.last ||
            delta_clamped_o !== want.clamped) begin
          report_mismatch($sformatf(
              "byte %0d: got data %02h last %0b clamped %0b, want %02h %0b %0b",
              byte_count, data_byte_o, last_o, delta_clamped_o,
              want.data, want.last, want.clamped));
        end
      end
      byte_count++;
    end
  end

  // Ends the run when neither side has completed a handshake for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no handshake for %0d cycles", QuietLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------

  task automatic push_event(logic op, int tick, int pitch, logic last_in);
    note_event_t ev;
    ev = '{op, 16'(tick), 8'(pitch), last_in};
    pending_events = {pending_events, ev};
    issued_count++;
  endtask

  // Waits until every item has been taken and every byte has arrived, then
  // keeps waiting, since an item that sends no byte may still be in work.
  task automatic wait_drained();
    @(negedge clk_i);
    while (accepted_count != issued_count || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Setup cycle, then access cycle; the register lands at the rising edge
  // of the access cycle once pready is high.
  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_TRANSPOSE: cfg_transpose = value[7:0];
      REG_LOWEST:    cfg_lowest    = value[6:0];
      REG_HIGHEST:   cfg_highest   = value[6:0];
      default:       cfg_offset    = value[6:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(int transpose, int lowest, int highest, int offset);
    write_register(REG_TRANSPOSE, 32'(transpose) & 32'hFF);
    write_register(REG_LOWEST, 32'(lowest));
    write_register(REG_HIGHEST, 32'(highest));
    write_register(REG_OFFSET, 32'(offset));
    @(posedge clk_i);
  endtask

  // Mostly well-formed songs: tick groups of one to four notes with rising
  // ticks and the group flag on the last note, now and then an end of song.
  // Mixed in are fully random items, groups that lose their flag, and rare
  // huge jumps that hit the delta cap.
  task automatic add_song(int count);
    int tick_now;
    int made;
    int group_len;
    int r;
    int pitch;
    tick_now = $urandom_range(40);
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_event(1'($urandom_range(1)), $urandom_range(65535), $urandom_range(255),
                   1'($urandom_range(1)));
        made++;
      end else if (r < 14) begin
        tick_now += $urandom_range(300);
        if (tick_now > 65535) tick_now = 65535;
        push_event(OP_END, tick_now, $urandom_range(255), 1'($urandom_range(1)));
        made++;
        tick_now = $urandom_range(40);
      end else begin
        if ($urandom_range(19) == 0) begin
          tick_now += $urandom_range(65535);
        end else begin
          tick_now += $urandom_range(700);
        end
        if (tick_now > 65535) tick_now = 65535;
        group_len = $urandom_range(4, 1);
        for (int g = 0; g < group_len; g++) begin
          r = $urandom_range(99);
          if (r < 8) begin
            pitch = MarkerPitch;
          end else if (r < 13) begin
            pitch = $urandom_range(255, 129);
          end else begin
            pitch = $urandom_range(127);
          end
          push_event(OP_NOTE, tick_now, pitch,
                     (g == group_len - 1) && ($urandom_range(9) != 0));
          made++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_idling(15, 73);

    // Directed part with the reset values written explicitly.
    apply_setting(0, 0, 127, 0);
    push_event(OP_NOTE, 0, 0, 1'b0);        // zero delta, note held back
    push_event(OP_NOTE, 0, 127, 1'b1);      // held note, then last with flag
    push_event(OP_NOTE, 255, 60, 1'b1);     // delta of exactly one full byte
    push_event(OP_NOTE, 100, 10, 1'b1);     // tick goes backwards
    push_event(OP_NOTE, 200, 1, 1'b0);
    push_event(OP_NOTE, 300, 2, 1'b0);      // new tick closes the open group
    push_event(OP_NOTE, 300, 255, 1'b1);    // last note dropped, held one closes
    push_event(OP_NOTE, 300, 129, 1'b1);    // dropped with nothing open
    push_event(OP_NOTE, 40000, 3, 1'b0);    // delta above the cap
    push_event(OP_END, 65535, 0, 1'b0);     // close, capped delta, end byte
    push_event(OP_NOTE, 65535, 128, 1'b1);  // marker in a fresh song
    push_event(OP_END, 0, 255, 1'b1);       // end going backwards
    push_event(OP_END, 0, 0, 1'b0);         // end right after a reset song
    wait_drained();

    // Most negative shift with the largest offset: the byte wraps around.
    apply_setting(-128, 0, 127, 127);
    push_event(OP_NOTE, 10, 255, 1'b0);
    push_event(OP_NOTE, 10, 130, 1'b0);
    push_event(OP_NOTE, 10, 0, 1'b1);
    push_event(OP_NOTE, 20, 128, 1'b1);
    wait_drained();

    // Empty range: only the marker gets through.
    apply_setting(127, 100, 0, 0);
    push_event(OP_NOTE, 30, 5, 1'b1);
    push_event(OP_NOTE, 30, 128, 1'b0);
    push_event(OP_END, 40, 7, 1'b0);
    wait_drained();

    // Single-pitch range at the top.
    apply_setting(0, 127, 127, 0);
    push_event(OP_NOTE, 1, 127, 1'b1);
    push_event(OP_NOTE, 2, 126, 1'b1);
    push_event(OP_END, 65535, 0, 1'b1);
    wait_drained();

    // Random songs, first with the receiver stalling often and one long
    // hold-off while the sender keeps offering items.
    apply_setting($urandom_range(40) - 20, $urandom_range(50), $urandom_range(127, 70),
                  $urandom_range(127));
    pressure_req = 1'b1;
    add_song(26);
    wait_drained();

    // The sender now idles more than the receiver.
    set_idling(73, 15);
    apply_setting($urandom_range(40) - 20, $urandom_range(50), $urandom_range(127, 70),
                  $urandom_range(127));
    add_song(26);
    wait_drained();

    // Back to back on both sides with the full range.
    set_idling(0, 0);
    apply_setting(0, 0, 127, $urandom_range(20));
    add_song(26);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
